/* rtl/dlgr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DVD LPCM group repacker package
// Shared constants, format decode and the job type passed from front to back.
// ----------------------------------------------------------------------------
package dlgr_pkg;

   localparam int unsigned GroupBytes = 12;

   localparam logic [1:0] WIDTH_16 = 2'd0;
   localparam logic [1:0] WIDTH_20 = 2'd1;
   localparam logic [1:0] WIDTH_24 = 2'd2;

   localparam logic [1:0] FMT_SEL_20 = 2'b01;
   localparam logic [1:0] FMT_SEL_24 = 2'b10;

   localparam logic [3:0] SIZE_20 = 4'd10;
   localparam logic [3:0] SIZE_24 = 4'd12;

   localparam logic [2:0] PREFIX_LAST = 3'd4;
   localparam logic [16:0] PAYLOAD_BASE = 17'd5;
   localparam logic [16:0] POS_MAX = 17'h1FFFF;

   localparam logic [3:0] MAP24 [GroupBytes] = '{
      4'd0, 4'd1, 4'd8, 4'd2, 4'd3, 4'd9, 4'd4, 4'd5, 4'd10, 4'd6, 4'd7, 4'd11
   };

   typedef struct packed {
      logic [1:0] width_code;
      logic       rate_high;
      logic [3:0] channel_count;
      logic       mute_flag;
      logic       emphasis_flag;
      logic [7:0] dyn_range;
   } format_type;

   typedef struct packed {
      logic [GroupBytes-1:0][7:0] data;
      logic [GroupBytes-1:0]      ap_mask;
      logic [3:0]                 count;
      format_type                 fmt;
   } job_type;

   function automatic logic [1:0] width_of(input logic [23:0] word);
      logic [1:0] sel;
      sel = word[15:14];
      if (sel == FMT_SEL_24) begin
         return WIDTH_24;
      end else if (sel == FMT_SEL_20) begin
         return WIDTH_20;
      end
      return WIDTH_16;
   endfunction

   function automatic format_type decode_format(input logic [23:0] word);
      format_type f;
      f.width_code    = width_of(word);
      f.rate_high     = word[12];
      f.channel_count = {1'b0, word[10:8]} + 4'd1;
      f.mute_flag     = word[22];
      f.emphasis_flag = word[23];
      f.dyn_range     = word[7:0];
      return f;
   endfunction

endpackage
`default_nettype wire

/* rtl/dlgr_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DVD LPCM group repacker channels
// Valid/ready channels for packet bytes in and PCM bytes out.
// ----------------------------------------------------------------------------
interface dlgr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       packet_start;
   logic       packet_end;

   modport source (output valid, data_byte, packet_start, packet_end, input ready);
   modport sink   (input valid, data_byte, packet_start, packet_end, output ready);
endinterface

interface dlgr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;
   logic       access_point;
   logic [1:0] width_code;
   logic       rate_high;
   logic [3:0] channel_count;
   logic       mute_flag;
   logic       emphasis_flag;
   logic [7:0] dyn_range;

   modport source (output valid, out_byte, last_of_run, access_point, width_code,
                   rate_high, channel_count, mute_flag, emphasis_flag, dyn_range,
                   input ready);
   modport sink   (input valid, out_byte, last_of_run, access_point, width_code,
                   rate_high, channel_count, mute_flag, emphasis_flag, dyn_range,
                   output ready);
endinterface
`default_nettype wire

/* rtl/dlgr_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DVD LPCM group repacker front
// Parse the packet prefix, collect payload groups and post output jobs.
// ----------------------------------------------------------------------------
module dlgr_front
   import dlgr_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   dlgr_req_if.sink   req_if,
   input  wire logic  push_ready,
   output logic       push_valid,
   output job_type    push_job
);

   logic [16:0] pos_ff, pos_in;
   logic [31:0] prefix_ff, prefix_in;
   logic [23:0] format_ff, format_in;
   logic        fvalid_ff, fvalid_in;
   logic [15:0] ao_ff, ao_in;
   logic [3:0]  fill_ff, fill_in;
   logic [7:0]  store_ff [GroupBytes];

   logic        accept;
   logic        st, en;
   logic [7:0]  b;
   logic [16:0] pos_e, p, ao_m4, s;
   logic [3:0]  fill_e, fill_w, nf, size, j;
   logic [1:0]  mode;
   logic        in_prefix, payload, ao_gt4, brk, ap_start, grouped;
   logic [7:0]  nstore [GroupBytes];
   job_type     job;

   assign accept = req_if.valid && req_if.ready;
   assign req_if.ready = push_ready;
   assign st = req_if.packet_start;
   assign en = req_if.packet_end;
   assign b  = req_if.data_byte;

   always_comb begin
      pos_e     = st ? 17'd0 : pos_ff;
      fill_e    = st ? 4'd0 : fill_ff;
      in_prefix = pos_e < PAYLOAD_BASE;
      payload   = !in_prefix && fvalid_ff;
      mode      = width_of(format_ff);
      grouped   = mode != WIDTH_16;
      size      = (mode == WIDTH_20) ? SIZE_20 : SIZE_24;
      p         = pos_e - PAYLOAD_BASE;
      ao_gt4    = ao_ff > 16'd4;
      ao_m4     = {1'b0, ao_ff} - 17'd4;
      brk       = ao_gt4 && (p == ao_m4);
      fill_w    = brk ? 4'd0 : fill_e;
      if (fill_w >= size) begin
         fill_w = 4'd0;
      end
      nf        = fill_w + 4'd1;
      s         = p + 17'd1 - {13'd0, nf};
      ap_start  = ao_gt4 && (s == ao_m4);
      j         = brk ? fill_e : fill_w;
      for (int i = 0; i < GroupBytes; i++) begin
         nstore[i]   = (4'(i) == fill_w) ? b : store_ff[i];
      end

      job.fmt     = decode_format(format_ff);
      job.ap_mask = '0;
      job.count   = 4'd0;
      for (int i = 0; i < GroupBytes; i++) begin
         job.data[i] = (4'(i) == j) ? b : store_ff[i];
      end

      if (!grouped) begin
         job.data[0]    = b;
         job.ap_mask[0] = brk;
         job.count      = 4'd1;
      end else if (nf == size) begin
         job.count      = 4'd12;
         job.ap_mask[0] = ap_start;
         if (mode == WIDTH_20) begin
            job.data[0]  = nstore[0];
            job.data[1]  = nstore[1];
            job.data[2]  = {nstore[8][7:4], 4'd0};
            job.data[3]  = nstore[2];
            job.data[4]  = nstore[3];
            job.data[5]  = {nstore[8][3:0], 4'd0};
            job.data[6]  = nstore[4];
            job.data[7]  = nstore[5];
            job.data[8]  = {nstore[9][7:4], 4'd0};
            job.data[9]  = nstore[6];
            job.data[10] = nstore[7];
            job.data[11] = {nstore[9][3:0], 4'd0};
         end else begin
            for (int i = 0; i < GroupBytes; i++) begin
               job.data[i] = nstore[MAP24[i]];
            end
         end
      end else if (mode == WIDTH_24) begin
         if (brk) begin
            job.count = fill_e + {3'd0, en};
            job.ap_mask[fill_e] = en;
         end else if (en) begin
            job.count      = nf;
            job.ap_mask[0] = ap_start;
         end
      end

      push_job   = job;
      push_valid = accept && payload && (job.count != 4'd0);

      pos_in    = pos_ff;
      prefix_in = prefix_ff;
      format_in = format_ff;
      fvalid_in = fvalid_ff;
      ao_in     = ao_ff;
      fill_in   = fill_ff;
      if (accept) begin
         if (en) begin
            pos_in = 17'd0;
         end else if (pos_e < POS_MAX) begin
            pos_in = pos_e + 17'd1;
         end else begin
            pos_in = pos_e;
         end
         if (in_prefix) begin
            prefix_in = {prefix_ff[23:0], b};
            if (pos_e[2:0] == PREFIX_LAST) begin
               ao_in     = prefix_ff[31:16];
               format_in = {prefix_ff[15:0], b};
               fvalid_in = fvalid_ff || ({prefix_ff[15:0], b} != 24'd0);
            end
         end
         if (en) begin
            fill_in = 4'd0;
         end else if (payload && grouped) begin
            fill_in = (nf == size) ? 4'd0 : nf;
         end else begin
            fill_in = fill_e;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         prefix_ff <= '0;
         format_ff <= '0;
         fvalid_ff <= 1'b0;
         ao_ff     <= '0;
         fill_ff   <= '0;
      end else begin
         pos_ff    <= pos_in;
         prefix_ff <= prefix_in;
         format_ff <= format_in;
         fvalid_ff <= fvalid_in;
         ao_ff     <= ao_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && payload && grouped) begin
         store_ff[fill_w] <= b;
      end
   end

endmodule
`default_nettype wire

/* rtl/dlgr_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DVD LPCM group repacker job queue
// Short first-in first-out store of jobs between front and back.
// ----------------------------------------------------------------------------
module dlgr_queue
   import dlgr_pkg::*;
#(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   input  wire job_type push_job,
   output logic         push_ready,
   output logic         head_valid,
   output job_type      head_job,
   input  wire logic    pop
);

   localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] CntFull = CntWidth'(DEPTH);

   job_type               mem [DEPTH];
   logic [PtrWidth-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CntWidth-1:0]   cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign push_ready = cnt_ff != CntFull;
   assign head_valid = cnt_ff != '0;
   assign head_job   = mem[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PtrLast) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PtrLast) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

/* rtl/dlgr_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DVD LPCM group repacker back
// Serialize each job into output words through a registered output stage.
// ----------------------------------------------------------------------------
module dlgr_back
   import dlgr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    head_valid,
   input  wire job_type head_job,
   output logic         pop,
   dlgr_rsp_if.source   rsp_if
);

   logic [3:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff;
   logic        last_ff, ap_ff;
   format_type  fmt_ff;
   logic        load, last;

   assign load = head_valid && (!valid_ff || rsp_if.ready);
   assign last = idx_ff == (head_job.count - 4'd1);
   assign pop  = load && last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = last ? 4'd0 : idx_ff + 4'd1;
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= head_job.data[idx_ff];
         ap_ff   <= head_job.ap_mask[idx_ff];
         last_ff <= last;
         fmt_ff  <= head_job.fmt;
      end
   end

   assign rsp_if.valid         = valid_ff;
   assign rsp_if.out_byte      = byte_ff;
   assign rsp_if.last_of_run   = last_ff;
   assign rsp_if.access_point  = ap_ff;
   assign rsp_if.width_code    = fmt_ff.width_code;
   assign rsp_if.rate_high     = fmt_ff.rate_high;
   assign rsp_if.channel_count = fmt_ff.channel_count;
   assign rsp_if.mute_flag     = fmt_ff.mute_flag;
   assign rsp_if.emphasis_flag = fmt_ff.emphasis_flag;
   assign rsp_if.dyn_range     = fmt_ff.dyn_range;

endmodule
`default_nettype wire

/* rtl/dvd_lpcm_group_repacker_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// A completed run is registered in the job queue, then in the back output register.
// Throughput: one output word per cycle while PCM side is ready, set by the back serializer.
// Input: one word per cycle at 16 and 24 bits, five in six at 20 bits, while PCM is ready.
// A queued job leaves as a run of up to 12 output words, one per cycle while PCM is ready.
// Reset: synchronous, clears prefix, format, fill and queue state; group bytes are not cleared.
// ----------------------------------------------------------------------------
// DVD LPCM group repacker
// Regroup DVD LPCM packet payload into big-endian PCM output words.
// ----------------------------------------------------------------------------
module dvd_lpcm_group_repacker_unit
   import dlgr_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic  clock,
   input  wire logic  reset,
   dlgr_req_if.sink   req_if,
   dlgr_rsp_if.source rsp_if
);

   logic    push_valid, push_ready, head_valid, pop;
   job_type push_job, head_job;

   dlgr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   dlgr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop)
   );

   dlgr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule
`default_nettype wire

/* dv/dlgr_repack_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DVD LPCM group repacker checker
// Watches the packet byte and PCM byte channels. Tracks prefix, format and
// grouping state for every accepted packet word, queues the PCM words it
// should cause, and compares every accepted PCM word field by field.
// ----------------------------------------------------------------------------
module dlgr_repack_check
   import dlgr_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   dlgr_req_if       req_mon,
   dlgr_rsp_if       rsp_mon,
   output int        error_count,
   output int        pending,
   output int        words_checked
);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       access_point;
      logic [1:0] width_code;
      logic       rate_high;
      logic [3:0] channel_count;
      logic       mute_flag;
      logic       emphasis_flag;
      logic [7:0] dyn_range;
   } pcm_word_type;

   pcm_word_type pcm_due [$];
   pcm_word_type run_buf [GroupBytes];
   int unsigned  run_len;

   logic [23:0] fmt_word;
   logic        fmt_seen;
   logic [16:0] pkt_pos;
   logic [39:0] prefix_sr;
   logic [15:0] access_ofs;
   logic [7:0]  group_buf [GroupBytes];
   int unsigned group_cnt;

   int fails   = 0;
   int checked = 0;

   function automatic logic [1:0] width_sel();
      case (fmt_word[15:14])
         FMT_SEL_24: return WIDTH_24;
         FMT_SEL_20: return WIDTH_20;
         default:    return WIDTH_16;
      endcase
   endfunction

   function automatic bit at_access(input int unsigned start);
      return access_ofs > 16'd4 && start == 32'(access_ofs) - 32'd4;
   endfunction

   task automatic add_word(input logic [7:0] b, input bit ap);
      pcm_word_type w;
      w.out_byte      = b;
      w.last_of_run   = 1'b0;
      w.access_point  = ap;
      w.width_code    = width_sel();
      w.rate_high     = fmt_word[12];
      w.channel_count = {1'b0, fmt_word[10:8]} + 4'd1;
      w.mute_flag     = fmt_word[22];
      w.emphasis_flag = fmt_word[23];
      w.dyn_range     = fmt_word[7:0];
      run_buf[run_len] = w;
      run_len++;
   endtask

   task automatic add_partial(input bit ap);
      int unsigned i;
      for (i = 0; i < group_cnt && i < GroupBytes; i++) begin
         add_word(group_buf[i], ap && i == 0);
      end
   endtask

   task automatic add_group(input logic [1:0] mode, input bit ap);
      logic [7:0]  d [GroupBytes];
      int unsigned i;
      if (mode == WIDTH_20) begin
         d[0]  = group_buf[0];
         d[1]  = group_buf[1];
         d[2]  = {group_buf[8][7:4], 4'h0};
         d[3]  = group_buf[2];
         d[4]  = group_buf[3];
         d[5]  = {group_buf[8][3:0], 4'h0};
         d[6]  = group_buf[4];
         d[7]  = group_buf[5];
         d[8]  = {group_buf[9][7:4], 4'h0};
         d[9]  = group_buf[6];
         d[10] = group_buf[7];
         d[11] = {group_buf[9][3:0], 4'h0};
      end else begin
         for (i = 0; i < GroupBytes; i++) begin
            d[i] = group_buf[MAP24[i]];
         end
      end
      for (i = 0; i < GroupBytes; i++) begin
         add_word(d[i], ap && i == 0);
      end
   endtask

   task automatic repack_byte(input logic [7:0] b, input logic st, input logic en);
      int unsigned p;
      int unsigned grp_size;
      int unsigned k;
      logic [1:0]  mode;
      bit          brk;
      run_len = 0;
      if (st) begin
         pkt_pos   = '0;
         group_cnt = 0;
      end
      if (pkt_pos < PAYLOAD_BASE) begin
         prefix_sr = {prefix_sr[31:0], b};
         if (pkt_pos == 17'(PREFIX_LAST)) begin
            access_ofs = prefix_sr[39:24];
            fmt_word   = prefix_sr[23:0];
            if (fmt_word != '0) begin
               fmt_seen = 1'b1;
            end
         end
      end else if (fmt_seen) begin
         p    = 32'(pkt_pos) - 32'(PAYLOAD_BASE);
         mode = width_sel();
         brk  = at_access(p);
         if (mode == WIDTH_16) begin
            add_word(b, brk);
         end else begin
            grp_size = (mode == WIDTH_20) ? 32'(SIZE_20) : 32'(SIZE_24);
            if (brk) begin
               if (mode == WIDTH_24) begin
                  add_partial(1'b0);
               end
               group_cnt = 0;
            end
            if (group_cnt >= grp_size) begin
               group_cnt = 0;
            end
            group_buf[group_cnt] = b;
            group_cnt++;
            if (group_cnt == grp_size) begin
               add_group(mode, at_access(p + 1 - grp_size));
               group_cnt = 0;
            end else if (en && mode == WIDTH_24) begin
               add_partial(at_access(p + 1 - group_cnt));
            end
         end
      end
      if (en) begin
         pkt_pos   = '0;
         group_cnt = 0;
      end else if (pkt_pos < POS_MAX) begin
         pkt_pos++;
      end
      for (k = 0; k < run_len; k++) begin
         run_buf[k].last_of_run = (k == run_len - 1);
         pcm_due.push_back(run_buf[k]);
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      pcm_word_type want;
      if (reset) begin
         fmt_word   = '0;
         fmt_seen   = 1'b0;
         pkt_pos    = '0;
         prefix_sr  = '0;
         access_ofs = '0;
         group_cnt  = 0;
         pcm_due.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            repack_byte(req_mon.data_byte, req_mon.packet_start, req_mon.packet_end);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pcm_due.size() == 0) begin
               $error("PCM word %0h arrived with nothing predicted", rsp_mon.out_byte);
               fails++;
            end else begin
               want = pcm_due.pop_front();
               check_field("out_byte", want.out_byte, rsp_mon.out_byte);
               check_field("last_of_run", want.last_of_run, rsp_mon.last_of_run);
               check_field("access_point", want.access_point, rsp_mon.access_point);
               check_field("width_code", want.width_code, rsp_mon.width_code);
               check_field("rate_high", want.rate_high, rsp_mon.rate_high);
               check_field("channel_count", want.channel_count, rsp_mon.channel_count);
               check_field("mute_flag", want.mute_flag, rsp_mon.mute_flag);
               check_field("emphasis_flag", want.emphasis_flag, rsp_mon.emphasis_flag);
               check_field("dyn_range", want.dyn_range, rsp_mon.dyn_range);
               checked++;
            end
         end
      end
      error_count   <= fails;
      pending       <= pcm_due.size();
      words_checked <= checked;
   end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DVD LPCM group repacker testbench
// Sends directed and random LPCM packets in all sample widths, with access
// points and broken packets, under random gaps on the packet side and
// random stalls on the PCM side.
// ----------------------------------------------------------------------------
module tb_top;
   import dlgr_pkg::*;

   localparam int unsigned     RandomBytes = 50;
   localparam int unsigned     CycleLimit  = 1500000;
   localparam logic [1:0]      SelRaw16    = 2'b00;
   localparam logic [1:0]      SelWide     = 2'b11;

   logic        clock = 1'b0;
   logic        reset;
   bit          steady = 1'b0;
   int unsigned cycles = 0;
   int unsigned bytes_sent = 0;
   int unsigned packets_sent = 0;
   int          error_count;
   int          pending;
   int          words_checked;

   dlgr_req_if req_ch ();
   dlgr_rsp_if rsp_ch ();

   dvd_lpcm_group_repacker_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   dlgr_repack_check repack_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .error_count   (error_count),
      .pending       (pending),
      .words_checked (words_checked)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (steady || r < 60) begin
         return 0;
      end
      if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [23:0] make_format(input logic [1:0] sel, input logic rate,
                                               input logic [2:0] ch, input logic mute,
                                               input logic emph, input logic [7:0] dyn);
      logic [23:0] w;
      w        = '0;
      w[23]    = emph;
      w[22]    = mute;
      w[15:14] = sel;
      w[12]    = rate;
      w[10:8]  = ch;
      w[7:0]   = dyn;
      return w;
   endfunction

   function automatic logic [16:0] rand_offset(input int unsigned payload);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 45) begin
         return 17'(5 + $urandom_range(payload));
      end
      if (r < 60) begin
         return 17'($urandom_range(4));
      end
      if (r < 80) begin
         return 17'(5 + $urandom_range(36));
      end
      return 17'($urandom_range(16'hFFFF));
   endfunction

   // stall the PCM side
   initial begin : pcm_stall
      int unsigned hold;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (steady) begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end else begin
            hold = pick_gap();
            if (hold != 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (hold) @(posedge clock);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   task automatic put_word(input logic [7:0] b, input logic st, input logic en);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.data_byte    <= b;
      req_ch.packet_start <= st;
      req_ch.packet_end   <= en;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_packet(input logic [15:0] ofs, input logic [23:0] fmt,
                              input int unsigned len, input bit mark_start,
                              input bit mark_end, input int fill);
      logic [39:0] head;
      logic [7:0]  b;
      int unsigned i;
      head = {ofs, fmt};
      for (i = 0; i < len; i++) begin
         if (i < 5) begin
            b = head[39 - 8 * i -: 8];
         end else if (fill < 0) begin
            b = 8'($urandom);
         end else begin
            b = 8'(fill);
         end
         put_word(b, mark_start && i == 0, mark_end && i == len - 1);
      end
      packets_sent++;
   endtask

   // hold the sender until every predicted PCM word has come back
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [23:0] f16;
      logic [23:0] f20;
      logic [23:0] f24;
      logic [23:0] fmt;
      logic [1:0]  sel;
      int unsigned payload;
      int unsigned r;
      int unsigned k;
      int unsigned random_base;

      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.data_byte    <= '0;
      req_ch.packet_start <= 1'b0;
      req_ch.packet_end   <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      f16 = make_format(SelRaw16, 1'b0, 3'd1, 1'b0, 1'b0, 8'h11);
      f20 = make_format(FMT_SEL_20, 1'b1, 3'd5, 1'b1, 1'b0, 8'h80);
      f24 = make_format(FMT_SEL_24, 1'b1, 3'd7, 1'b0, 1'b1, 8'h3C);

      // drop payload before any format, short and single-byte packets
      send_packet(16'd6, 24'h000000, 8, 1'b1, 1'b1, -1);
      send_packet(16'd5, f24, 3, 1'b1, 1'b1, -1);
      send_packet(16'd0, 24'h000000, 1, 1'b1, 1'b1, -1);
      // 16-bit, every format field at its top, access point on payload byte 3
      send_packet(16'd7, 24'hFF3FFF, 9, 1'b1, 1'b1, 8'hFF);
      // width bits 11, every other field clear, offset without access point
      send_packet(16'd4, make_format(SelWide, 1'b0, 3'd0, 1'b0, 1'b0, 8'h00), 8,
                  1'b1, 1'b1, 8'h00);
      send_packet(16'd0, make_format(FMT_SEL_20, 1'b0, 3'd1, 1'b0, 1'b0, 8'h00), 15,
                  1'b1, 1'b1, 8'hFF);
      send_packet(16'd8, f20, 19, 1'b1, 1'b1, -1);
      send_packet(16'd14, f20, 29, 1'b1, 1'b1, -1);
      send_packet(16'd9, f24, 25, 1'b1, 1'b1, -1);
      send_packet(16'd16, f24, 22, 1'b1, 1'b1, -1);
      send_packet(16'hFFFF, make_format(FMT_SEL_24, 1'b0, 3'd0, 1'b0, 1'b0, 8'h00), 17,
                  1'b1, 1'b1, 8'h00);
      // zero format word once a valid one was seen
      send_packet(16'd6, 24'h000000, 8, 1'b1, 1'b1, -1);
      // packet without end, then without start
      send_packet(16'd0, f24, 12, 1'b1, 1'b0, -1);
      send_packet(16'd0, f24, 17, 1'b1, 1'b1, -1);
      send_packet(16'd5, f20, 15, 1'b0, 1'b1, -1);
      send_packet(16'd1, f16, 7, 1'b1, 1'b1, -1);
      drain_results();

      random_base = bytes_sent;
      while (bytes_sent < random_base + RandomBytes) begin
         steady  = ($urandom_range(99) < 15);
         payload = ($urandom_range(9) == 0) ? $urandom_range(40, 60) : $urandom_range(26);
         r       = $urandom_range(9);
         sel     = (r < 3) ? SelRaw16 : (r < 6) ? FMT_SEL_20 : (r < 9) ? FMT_SEL_24 : SelWide;
         fmt     = 24'($urandom);
         fmt[15:14] = sel;
         if (fmt == '0) begin
            fmt[0] = 1'b1;
         end
         r = $urandom_range(99);
         if (r < 78) begin
            send_packet(16'(rand_offset(payload)), fmt, 5 + payload, 1'b1, 1'b1, -1);
         end else if (r < 84) begin
            send_packet(16'(rand_offset(payload)), fmt, 5 + payload, 1'b1, 1'b0, -1);
         end else if (r < 89) begin
            send_packet(16'(rand_offset(payload)), fmt, 5 + payload, 1'b0, 1'b1, -1);
         end else if (r < 93) begin
            send_packet(16'(rand_offset(payload)), fmt, $urandom_range(1, 4), 1'b1, 1'b1, -1);
         end else if (r < 96) begin
            send_packet(16'(rand_offset(payload)), 24'h000000, 5 + payload, 1'b1, 1'b1, -1);
         end else begin
            for (k = 0; k < $urandom_range(1, 12); k++) begin
               put_word(8'($urandom), $urandom_range(7) == 0, $urandom_range(7) == 0);
            end
         end
         if ($urandom_range(19) == 0) begin
            drain_results();
         end
      end
      steady = 1'b0;

      drain_results();
      repeat (30) @(posedge clock);

      $display("Checked %0d PCM words from %0d packet words in %0d packets",
               words_checked, bytes_sent, packets_sent);
      $display("Covered 16/20/24-bit groups, access points, broken and short packets");
      if (error_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
